// ===== hdl/rmea_pkg.sv =====
// Shared constants, types and helpers for the rotation matrix to Euler angles block.
package rmea_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int ELEM_W = 16;
	localparam int ANGLE_W = 16;
	localparam int THR_W = 15;
	// two full-scale squares add up to 2^31, so the sum needs 32 bits
	localparam int SUM_W = 32;
	localparam int ROOT_W = 16;
	// CORDIC datapath: 17-bit operand * 2^14, plus growth
	localparam int CX_W = 36;
	localparam int CZ_W = 28;
	localparam logic signed [CZ_W-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [ANGLE_W-1:0] PI_Q13 = 16'sd25736;
	localparam logic [7:0] ADDR_THR = 8'd0;

	typedef logic signed [CX_W-1:0] cx_t;
	typedef logic signed [CZ_W-1:0] cz_t;

	typedef struct packed {
		cx_t x;
		cx_t y;
		cz_t z;
		logic zero;
	} cvec_t;

	function automatic cz_t atan_entry(input int i);
		cz_t t;
		case (i)
			0: t = 28'sd13176795;
			1: t = 28'sd7778716;
			2: t = 28'sd4110060;
			3: t = 28'sd2086331;
			4: t = 28'sd1047214;
			5: t = 28'sd524117;
			6: t = 28'sd262123;
			7: t = 28'sd131069;
			default: t = cz_t'(28'sd1 <<< (24 - i));
		endcase
		return t;
	endfunction

	// Operand setup with quadrant pre-rotation.
	function automatic cvec_t cordic_init(input logic signed [16:0] y, input logic signed [16:0] x);
		cvec_t v;
		cx_t xs;
		cx_t ys;
		xs = cx_t'(x) <<< 14;
		ys = cx_t'(y) <<< 14;
		v.zero = (x == 17'sd0) && (y == 17'sd0);
		v.x = xs;
		v.y = ys;
		v.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				v.x = ys;
				v.y = -xs;
				v.z = HALF_PI_Q24;
			end else begin
				v.x = -ys;
				v.y = xs;
				v.z = -HALF_PI_Q24;
			end
		end
		return v;
	endfunction

	function automatic cvec_t cordic_step(input cvec_t v, input int i);
		cvec_t o;
		o = v;
		if (v.y >= 0) begin
			o.x = v.x + (v.y >>> i);
			o.y = v.y - (v.x >>> i);
			o.z = v.z + atan_entry(i);
		end else begin
			o.x = v.x - (v.y >>> i);
			o.y = v.y + (v.x >>> i);
			o.z = v.z - atan_entry(i);
		end
		return o;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] cordic_final(input cvec_t v);
		cz_t r;
		logic signed [ANGLE_W-1:0] a;
		r = (v.z + cz_t'(1024)) >>> 11;
		if (r > cz_t'(PI_Q13)) a = PI_Q13;
		else if (r < -cz_t'(PI_Q13)) a = -PI_Q13;
		else a = r[ANGLE_W-1:0];
		if (v.zero) a = '0;
		return a;
	endfunction

endpackage

// ===== hdl/rotation_matrix_to_euler_angles.sv =====
// Top level: pipelined rotation matrix to x-y-z Euler angle converter.
//
// Usage: drive the seven Q2.14 matrix elements and pulse start. busy is tied
// low, so one transfer can be started in every cycle. Each result appears on
// angle_x/angle_y/angle_z/is_singular for exactly one cycle with done high.
// Throughput: one item per cycle, set by the fully unrolled pipeline: one
// root bit per stage in the square root, then one CORDIC micro-rotation per
// stage in each of three parallel atan2 lanes. Stage 1 registers the
// operands, stage 2 forms r00^2 + r10^2 (two 16x16 multipliers), the root
// stages recover sy bit by bit, an entry stage does the threshold compare
// and the quadrant pre-rotation, then the lanes for angle_x, angle_y and
// angle_z run in lockstep and a last stage rounds and saturates.
// Reset: arst_n clears all valid bits and sets singular_threshold to 1;
// items in flight are dropped. The receiver cannot stall the block, so no
// backpressure path exists. singular_threshold is read over APB at address 0
// and the user must write it only while no transfer is in flight; unenforced.
module rotation_matrix_to_euler_angles #(
	parameter int CORDIC_STEPS = rmea_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_0_0,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_1_0,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_2_0,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_2_1,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_2_2,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_1_1,
	input  logic signed [rmea_pkg::ELEM_W-1:0] r_1_2,
	output logic done,
	output logic signed [rmea_pkg::ANGLE_W-1:0] angle_x,
	output logic signed [rmea_pkg::ANGLE_W-1:0] angle_y,
	output logic signed [rmea_pkg::ANGLE_W-1:0] angle_z,
	output logic is_singular,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rmea_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int RS = ROOT_W;

	logic [THR_W-1:0] thr_q;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign prdata = (paddr == ADDR_THR[1:0]) ? {{(32-THR_W){1'b0}}, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (psel && penable && pwrite && (paddr == ADDR_THR[1:0])) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// element bundle carried through the root stages
	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
	} elem_t;

	// stage 1: capture
	logic  v_s1;
	elem_t e_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		e_s1 <= '{r_0_0, r_1_0, r_2_0, r_2_1, r_2_2, r_1_1, r_1_2};
	end

	// stage 2: sum of squares
	logic v_s2;
	elem_t e_s2;
	logic [SUM_W-1:0] sum_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		e_s2 <= e_s1;
		sum_s2 <= SUM_W'($unsigned(32'(e_s1.r00) * 32'(e_s1.r00))
			+ $unsigned(32'(e_s1.r10) * 32'(e_s1.r10)));
	end

	// root stages: restoring square root, one result bit per stage
	logic  rv [RS+1];
	elem_t re [RS+1];
	logic [SUM_W:0] rrem [RS+1];
	logic [ROOT_W-1:0] rroot [RS+1];
	assign rv[0] = v_s2;
	assign re[0] = e_s2;
	assign rrem[0] = {1'b0, sum_s2};
	assign rroot[0] = '0;

	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam int B = RS - 1 - k;
		logic [SUM_W+1:0] trial;
		logic [SUM_W+1:0] cand;
		always_comb begin
			trial = ({{(SUM_W+2-ROOT_W){1'b0}}, rroot[k]} << (B + 1))
				+ ((SUM_W+2)'(1) << (2 * B));
			cand = {1'b0, rrem[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[k+1] <= 1'b0;
			else rv[k+1] <= rv[k];
		end
		always_ff @(posedge clk) begin
			re[k+1] <= re[k];
			if (cand >= trial) begin
				rrem[k+1] <= (SUM_W+1)'(cand - trial);
				rroot[k+1] <= rroot[k] | (ROOT_W'(1) << B);
			end else begin
				rrem[k+1] <= rrem[k];
				rroot[k+1] <= rroot[k];
			end
		end
	end

	// CORDIC entry: compare threshold, pick operands, pre-rotate
	logic  cv [STEPS+1];
	logic  cs [STEPS+1];
	cvec_t cxl [STEPS+1];
	cvec_t cyl [STEPS+1];
	cvec_t czl [STEPS+1];
	logic  sing_w;
	elem_t ef;
	always_comb begin
		ef = re[RS];
		sing_w = {1'b0, rroot[RS]} < {2'b0, thr_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv[0] <= 1'b0;
		else cv[0] <= rv[RS];
	end
	always_ff @(posedge clk) begin
		cs[0] <= sing_w;
		cyl[0] <= cordic_init(-17'(ef.r20), {1'b0, rroot[RS]});
		if (!sing_w) begin
			cxl[0] <= cordic_init(17'(ef.r21), 17'(ef.r22));
		end else begin
			cxl[0] <= cordic_init(-17'(ef.r12), 17'(ef.r11));
		end
		czl[0] <= cordic_init(17'(ef.r10), 17'(ef.r00));
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv[i+1] <= 1'b0;
			else cv[i+1] <= cv[i];
		end
		always_ff @(posedge clk) begin
			cs[i+1] <= cs[i];
			cxl[i+1] <= cordic_step(cxl[i], i);
			cyl[i+1] <= cordic_step(cyl[i], i);
			czl[i+1] <= cordic_step(czl[i], i);
		end
	end

	// output stage: round, saturate, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cv[STEPS];
	end
	always_ff @(posedge clk) begin
		angle_x <= cordic_final(cxl[STEPS]);
		angle_y <= cordic_final(cyl[STEPS]);
		angle_z <= cs[STEPS] ? '0 : cordic_final(czl[STEPS]);
		is_singular <= cs[STEPS];
	end

endmodule

// ===== hdl/rmea_checker.sv =====
// Port-level checker for the Euler angle converter, bound to the top level.
module rmea_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic done,
	input logic signed [15:0] angle_x,
	input logic signed [15:0] angle_y,
	input logic signed [15:0] angle_z,
	input logic is_singular,
	input logic pready
);
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_singular) |-> (angle_z == 16'sd0))
		else $error("angle_z nonzero when singular");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_x <= 16'sd25736 && angle_x >= -16'sd25736
			&& angle_y <= 16'sd25736 && angle_y >= -16'sd25736))
		else $error("angle out of range");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind rotation_matrix_to_euler_angles rmea_checker u_rmea_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done), .angle_x(angle_x),
	.angle_y(angle_y), .angle_z(angle_z), .is_singular(is_singular), .pready(pready)
);

// ===== tb/rotation_matrix_to_euler_angles_test.sv =====
// Testbench for the rotation matrix to Euler angles converter.
module rotation_matrix_to_euler_angles_test;
	import rmea_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = 3 + ROOT_W + STEPS + 1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 1930;
	localparam int N_DIRECTED = 20;

	typedef logic signed [15:0] elem_t;
	typedef logic signed [15:0] ang_t;

	// one matrix transfer: r00 r10 r20 r21 r22 r11 r12
	typedef struct {
		elem_t e [7];
	} matrix_t;

	typedef struct {
		ang_t ax;
		ang_t ay;
		ang_t az;
		logic sing;
	} euler_t;

	// directed row: matrix, and whether the angles are typed in by hand
	typedef struct {
		matrix_t m;
		logic typed;
		euler_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	elem_t r_0_0 = '0, r_1_0 = '0, r_2_0 = '0, r_2_1 = '0, r_2_2 = '0,
		r_1_1 = '0, r_1_2 = '0;
	logic done;
	ang_t angle_x, angle_y, angle_z;
	logic is_singular;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rotation_matrix_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// predictor state: the threshold register as the block should hold it
	logic [14:0] thr_model = 15'd1;
	euler_t angles_pending[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int singular_seen = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;

	// Vectoring CORDIC, 64-bit arithmetic so nothing wraps.
	function automatic ang_t vec_angle(longint y0, longint x0);
		longint x, y, z, t, dx, dy;
		longint tab [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		if (x0 == 0 && y0 == 0) return '0;
		x = x0 * 16384;
		y = y0 * 16384;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 26353589;
			end else begin
				t = x; x = -y; y = t; z = -26353589;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += tab[i];
			end else begin
				x -= dx; y += dy; z -= tab[i];
			end
		end
		z = (z + 1024) >>> 11;
		if (z > 25736) z = 25736;
		if (z < -25736) z = -25736;
		return ang_t'(z);
	endfunction

	function automatic euler_t predict_euler(matrix_t m);
		euler_t r;
		longint r00, r10, sum, root, b;
		r00 = m.e[0];
		r10 = m.e[1];
		sum = r00 * r00 + r10 * r10;
		// floor square root, bit by bit
		root = 0;
		b = 64'd1 << 32;
		while (b > sum) b >>= 2;
		while (b != 0) begin
			if (sum >= root + b) begin
				sum -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		r.sing = root < thr_model;
		r.ay = vec_angle(-longint'(m.e[2]), root);
		if (!r.sing) begin
			r.ax = vec_angle(m.e[3], m.e[4]);
			r.az = vec_angle(m.e[1], m.e[0]);
		end else begin
			r.ax = vec_angle(-longint'(m.e[6]), m.e[5]);
			r.az = '0;
		end
		return r;
	endfunction

	// result side: done is a one-cycle strobe, sampled at the edge
	always @(posedge clk) begin
		if (arst_n && done) begin
			euler_t w;
			results_seen++;
			if (is_singular) singular_seen++;
			if (angles_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $time);
			end else begin
				w = angles_pending.pop_front();
				if (w.ax !== angle_x || w.ay !== angle_y || w.az !== angle_z ||
						w.sing !== is_singular) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want x=%0d y=%0d z=%0d s=%0b got x=%0d y=%0d z=%0d s=%0b",
							w.ax, w.ay, w.az, w.sing, angle_x, angle_y, angle_z, is_singular);
				end
			end
		end
	end

	// watchdog: cycles in which neither a transfer nor a result happens
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_THR[1:0]; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		thr_model = value[14:0];
	endtask

	task automatic apb_read_check(logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_THR[1:0];
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[14:0] !== want[14:0]) begin
			mismatches++;
			if (mismatches <= 10) $display("threshold read %0d, want %0d", prdata, want);
		end
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// Present one matrix; start stays high across back-to-back transfers.
	task automatic send_matrix(matrix_t m, logic typed, euler_t want);
		euler_t exp_r;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{r_0_0, r_1_0, r_2_0, r_2_1, r_2_2, r_1_1, r_1_2} <=
			{m.e[0], m.e[1], m.e[2], m.e[3], m.e[4], m.e[5], m.e[6]};
		do @(posedge clk); while (busy);
		exp_r = typed ? want : predict_euler(m);
		angles_pending = {angles_pending, exp_r};
		items_sent++;
	endtask

	// Quiet the block before a register write.
	task automatic drain();
		start <= 1'b0;
		while (angles_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(9, 0))
			0: return elem_t'($urandom());     // full 16-bit range of Q2.14, beyond +-1.0 too
			1: return elem_t'($urandom_range(4, 0)) - 16'sd2;
			2: return $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
			default: return elem_t'($urandom_range(32768, 0)) - 16'sd16384;
		endcase
	endfunction

	// random elements; pick a small r00/r10 now and then to hit gimbal lock
	function automatic matrix_t rand_matrix();
		matrix_t m;
		for (int k = 0; k < 7; k++) m.e[k] = rand_elem();
		if ($urandom_range(3, 0) == 0) begin
			m.e[0] = elem_t'($urandom_range(200, 0)) - 16'sd100;
			m.e[1] = elem_t'($urandom_range(200, 0)) - 16'sd100;
		end
		return m;
	endfunction

	function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
		matrix_t m;
		m.e = '{elem_t'(a), elem_t'(b), elem_t'(c), elem_t'(d), elem_t'(e),
			elem_t'(f), elem_t'(g)};
		return m;
	endfunction

	row_t stim [N_DIRECTED];
	euler_t none;

	initial begin
		none = '{ax: '0, ay: '0, az: '0, sing: 1'b0};
		// identity and all-zero matrices have answers that can be read off directly
		stim[0] = '{mk(16384, 0, 0, 0, 16384, 16384, 0), 1'b1, none};
		stim[1] = '{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, '{ax: '0, ay: '0, az: '0, sing: 1'b1}};
		// zero y, negative x: pi on x and z
		stim[2] = '{mk(-16384, 0, 0, 0, -16384, 16384, 0), 1'b1,
			'{ax: PI_Q13, ay: '0, az: PI_Q13, sing: 1'b0}};
		stim[3] = '{mk(0, 0, -16384, 16384, 0, 16384, 0), 0, none};
		stim[4] = '{mk(0, 0, 16384, 0, 0, 0, -16384), 0, none};
		stim[5] = '{mk(-16384, -16384, -16384, -16384, -16384, -16384, -16384), 0, none};
		stim[6] = '{mk(16384, 16384, 16384, 16384, 16384, 16384, 16384), 0, none};
		stim[7] = '{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, none};
		stim[8] = '{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 0, none};
		stim[9] = '{mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768), 0, none};
		stim[10] = '{mk(11585, 11585, 0, 11585, -11585, -1, 1), 0, none};
		stim[11] = '{mk(1, 0, 0, -1, -1, 1, 1), 0, none};
		stim[12] = '{mk(0, 1, 0, 1, 0, 0, 0), 0, none};
		stim[13] = '{mk(-1, -1, 1, -1, 0, -5, 5), 0, none};
		stim[14] = '{mk(14189, 8192, -8192, 4096, 14189, 16384, -8192), 0, none};
		stim[15] = '{mk(0, 0, 0, 0, 0, -16384, 0), 0, none};
		stim[16] = '{mk(0, 0, 0, 0, 0, 0, 16384), 0, none};
		stim[17] = '{mk(-21846, 5461, 21845, -21846, -1, 21845, -21846), 0, none};
		stim[18] = '{mk(100, -100, 0, 0, 0, 3, -7), 0, none};
		stim[19] = '{mk(16383, -16383, 1, 16383, 1, -16383, 16383), 0, none};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read_check(32'd1);

		for (int k = 0; k < N_DIRECTED; k++) send_matrix(stim[k].m, stim[k].typed, stim[k].want);
		drain();

		// threshold settings, extremes included; three idle profiles across them
		for (int ph = 0; ph < 6; ph++) begin
			logic [31:0] th;
			case (ph)
				0: th = 32'd0;
				1: th = 32'd16384;
				2: th = 32'd32767;
				3: th = 32'd8192;
				4: th = 32'd100;
				default: th = {$urandom()} & 32'h7fff;
			endcase
			apb_write(th);
			apb_read_check(th);
			send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 66 : 0;
			for (int k = 0; k < N_RANDOM / 6; k++) begin
				send_matrix(rand_matrix(), 1'b0, none);
				// hold off once per setting until every result is back
				if (k == 100) begin
					start <= 1'b0;
					while (angles_pending.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		$display("sent %0d matrices over 6 threshold settings, %0d results, %0d singular",
			items_sent, results_seen, singular_seen);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
